// ----- hw/rtl/olsd_pkg.sv -----
`default_nettype none

package olsd_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int SAMPLE_FIELDS = 9;
  localparam int OP_W          = 2;
  localparam int MARGIN_W      = 10;
  localparam int RUNLEN_W      = 8;
  localparam int RUN_W         = 8;
  localparam int WIN_CNT_W     = 16;
  localparam int TX_W          = 8;
  localparam int PHASE_W       = 2;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 10;
  localparam int IN_DATA_W     = 96;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 16;
  localparam int Q_DEPTH       = 4;

  localparam int CHANNELS_DEF    = 9;
  localparam int CAL_SWEEPS_DEF  = 100;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam logic [OP_W-1:0] OP_SWEEP = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_RECAL = 2'd2;

  localparam logic [PHASE_W-1:0] PH_CAL = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MON = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WIN = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_MARGIN     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RUN_LENGTH = 1'd1;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd3;
  localparam logic [RUNLEN_W-1:0] RUNLEN_RST = 8'd200;

  localparam logic [TX_W-1:0] BYTE_START = 8'h55;
  localparam logic [TX_W-1:0] BYTE_LOST  = 8'h66;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] avg;
  } item_t;

  typedef struct packed {
    logic                detect;
    logic                tx_valid;
    logic [TX_W-1:0]     tx_byte;
    logic                decision_valid;
    logic                locked;
    logic [PHASE_W-1:0]  phase;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/olsd_front.sv -----
`default_nettype none

module olsd_front #(
  parameter int CHANNELS    = olsd_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = olsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [olsd_pkg::IN_DATA_W-1:0] in_data,
  input  wire logic [olsd_pkg::OP_W-1:0]      in_op,
  output logic                                push_valid,
  input  wire logic                           push_full,
  output olsd_pkg::item_t                     push_item
);

  localparam int SW     = olsd_pkg::SAMPLE_W;
  localparam int SUM_W  = SW + $clog2(CHANNELS);
  localparam int DIV_K  = SUM_W + $clog2(CHANNELS);
  localparam int PROD_W = SUM_W + DIV_K + 1;
  localparam logic [DIV_K:0] RECIP =
    (DIV_K + 1)'(((1 << DIV_K) + CHANNELS - 1) / CHANNELS);
  localparam logic [SW-1:0] SMASK =
    (SAMPLE_BITS >= SW) ? {SW{1'b1}} : SW'((1 << SAMPLE_BITS) - 1);

  logic                        s1_v_r, s1_v_nxt;
  logic [olsd_pkg::OP_W-1:0]   s1_op_r, s1_op_nxt;
  logic [SUM_W-1:0]            s1_sum_r, s1_sum_nxt;
  logic [SUM_W-1:0]            sum_c;
  logic [PROD_W-1:0]           prod_c;

  // sweep sum, channels past the configured count read as zero
  always_comb begin
    sum_c = '0;
    for (int c = 0; c < olsd_pkg::SAMPLE_FIELDS; c++) begin
      if (c < CHANNELS) begin
        sum_c = sum_c + SUM_W'(in_data[c*SW +: SW] & SMASK);
      end
    end
  end

  assign in_ready = !s1_v_r || !push_full;

  always_comb begin
    s1_v_nxt   = s1_v_r;
    s1_op_nxt  = s1_op_r;
    s1_sum_nxt = s1_sum_r;
    if (in_ready) begin
      s1_v_nxt = in_valid;
      if (in_valid) begin
        s1_op_nxt  = in_op;
        s1_sum_nxt = sum_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    s1_op_r  <= s1_op_nxt;
    s1_sum_r <= s1_sum_nxt;
  end

  // exact divide by channel count through a rounded-up reciprocal
  assign prod_c         = PROD_W'(s1_sum_r) * PROD_W'(RECIP);
  assign push_valid     = s1_v_r;
  assign push_item.op   = s1_op_r;
  assign push_item.avg  = prod_c[DIV_K +: SW];

endmodule

`default_nettype wire

// ----- hw/rtl/olsd_queue.sv -----
`default_nettype none

module olsd_queue #(
  parameter int DEPTH = olsd_pkg::Q_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_full,
  input  wire olsd_pkg::item_t push_item,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output olsd_pkg::item_t      q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  olsd_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push;

  assign push_full = (cnt_r == CNT_W'(DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = push_valid && !push_full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/olsd_back.sv -----
`default_nettype none

module olsd_back #(
  parameter int CAL_SWEEPS = olsd_pkg::CAL_SWEEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [olsd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [olsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             q_valid,
  input  wire olsd_pkg::item_t                  q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output olsd_pkg::result_t                     out_res
);

  localparam int SW      = olsd_pkg::SAMPLE_W;
  localparam int CIDX_W  = $clog2(CAL_SWEEPS + 1);
  localparam int CSUM_W  = SW + CIDX_W;
  localparam int CAL_K   = CSUM_W + CIDX_W;
  localparam int CPROD_W = CSUM_W + CAL_K + 1;
  localparam logic [CAL_K:0] CAL_RECIP =
    (CAL_K + 1)'(((1 << CAL_K) + CAL_SWEEPS - 1) / CAL_SWEEPS);
  localparam int THR_W   = SW + 2;

  logic [olsd_pkg::MARGIN_W-1:0]  margin_r, margin_nxt;
  logic [olsd_pkg::RUNLEN_W-1:0]  runlen_r, runlen_nxt;
  logic [olsd_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [SW-1:0]                  amb_r, amb_nxt;
  logic [olsd_pkg::RUN_W-1:0]     run_r, run_nxt;
  logic [CIDX_W-1:0]              cidx_r, cidx_nxt;
  logic [CSUM_W-1:0]              csum_r, csum_nxt;
  logic [olsd_pkg::WIN_CNT_W-1:0] ones_r, ones_nxt;
  logic [olsd_pkg::WIN_CNT_W-1:0] zeros_r, zeros_nxt;
  logic                           lock_r, lock_nxt;
  logic                           amb_pend_r, amb_pend_nxt;
  logic [CSUM_W-1:0]              ctot_r, ctot_nxt;
  logic                           out_v_r, out_v_nxt;
  olsd_pkg::result_t              out_res_r, out_res_nxt;

  logic [THR_W-1:0]               thr;
  logic                           det;
  logic [CIDX_W-1:0]              cidx_inc;
  logic [CSUM_W-1:0]              csum_add;
  logic [olsd_pkg::RUN_W-1:0]     run_inc;
  logic [olsd_pkg::RUN_W-1:0]     run_tmp;
  logic [CPROD_W-1:0]             cprod;
  logic [SW-1:0]                  amb_div;
  olsd_pkg::result_t              res;

  assign thr      = {2'b00, amb_r} - {2'b00, margin_r};
  assign det      = $signed({2'b00, q_item.avg}) < $signed(thr);
  assign cidx_inc = cidx_r + 1'b1;
  assign csum_add = csum_r + CSUM_W'(q_item.avg);
  assign run_inc  = (run_r == '1) ? run_r : run_r + 1'b1;
  assign cprod    = CPROD_W'(ctot_r) * CPROD_W'(CAL_RECIP);
  assign amb_div  = cprod[CAL_K +: SW];

  // ambient divide takes the cycle after calibration ends
  assign q_pop     = q_valid && !amb_pend_r && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  always_comb begin
    margin_nxt   = margin_r;
    runlen_nxt   = runlen_r;
    phase_nxt    = phase_r;
    amb_nxt      = amb_r;
    run_nxt      = run_r;
    cidx_nxt     = cidx_r;
    csum_nxt     = csum_r;
    ones_nxt     = ones_r;
    zeros_nxt    = zeros_r;
    lock_nxt     = lock_r;
    amb_pend_nxt = amb_pend_r;
    ctot_nxt     = ctot_r;
    out_res_nxt  = out_res_r;
    out_v_nxt    = out_v_r && !out_ready;
    run_tmp      = '0;
    res          = '0;

    if (amb_pend_r) begin
      amb_nxt      = amb_div;
      amb_pend_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_addr)
        olsd_pkg::REG_MARGIN:     margin_nxt = cfg_wdata[olsd_pkg::MARGIN_W-1:0];
        olsd_pkg::REG_RUN_LENGTH: runlen_nxt = cfg_wdata[olsd_pkg::RUNLEN_W-1:0];
        default: ;
      endcase
    end

    if (q_pop) begin
      out_v_nxt = 1'b1;
      case (q_item.op)
        olsd_pkg::OP_RECAL: begin
          phase_nxt = olsd_pkg::PH_CAL;
          cidx_nxt  = '0;
          csum_nxt  = '0;
          run_nxt   = '0;
          ones_nxt  = '0;
          zeros_nxt = '0;
          lock_nxt  = 1'b0;
        end
        olsd_pkg::OP_SWEEP: begin
          case (phase_r)
            olsd_pkg::PH_CAL: begin
              csum_nxt = csum_add;
              cidx_nxt = cidx_inc;
              if (cidx_inc >= CIDX_W'(CAL_SWEEPS)) begin
                ctot_nxt     = csum_add;
                amb_pend_nxt = 1'b1;
                cidx_nxt     = '0;
                csum_nxt     = '0;
                run_nxt      = '0;
                phase_nxt    = olsd_pkg::PH_MON;
              end
            end
            olsd_pkg::PH_MON: begin
              res.detect = det;
              run_tmp    = det ? run_inc : '0;
              run_nxt    = run_tmp;
              if (run_tmp > runlen_r) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = olsd_pkg::BYTE_START;
                ones_nxt     = '0;
                zeros_nxt    = '0;
                run_nxt      = '0;
                phase_nxt    = olsd_pkg::PH_WIN;
              end
            end
            olsd_pkg::PH_WIN: begin
              res.detect = det;
              if (det) begin
                if (ones_r != '1) ones_nxt = ones_r + 1'b1;
              end else begin
                if (zeros_r != '1) zeros_nxt = zeros_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
        olsd_pkg::OP_TICK: begin
          if (phase_r == olsd_pkg::PH_WIN) begin
            res.decision_valid = 1'b1;
            lock_nxt           = (ones_r >= zeros_r);
            if (ones_r < zeros_r) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = olsd_pkg::BYTE_LOST;
            end
            run_nxt   = '0;
            phase_nxt = olsd_pkg::PH_MON;
          end
        end
        default: ;
      endcase
      res.locked  = lock_nxt;
      res.phase   = phase_nxt;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r   <= olsd_pkg::MARGIN_RST;
      runlen_r   <= olsd_pkg::RUNLEN_RST;
      phase_r    <= olsd_pkg::PH_CAL;
      amb_r      <= '0;
      run_r      <= '0;
      cidx_r     <= '0;
      csum_r     <= '0;
      ones_r     <= '0;
      zeros_r    <= '0;
      lock_r     <= 1'b0;
      amb_pend_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      margin_r   <= margin_nxt;
      runlen_r   <= runlen_nxt;
      phase_r    <= phase_nxt;
      amb_r      <= amb_nxt;
      run_r      <= run_nxt;
      cidx_r     <= cidx_nxt;
      csum_r     <= csum_nxt;
      ones_r     <= ones_nxt;
      zeros_r    <= zeros_nxt;
      lock_r     <= lock_nxt;
      amb_pend_r <= amb_pend_nxt;
      out_v_r    <= out_v_nxt;
    end
    ctot_r    <= ctot_nxt;
    out_res_r <= out_res_nxt;
  end

  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    amb_pend_r |=> !amb_pend_r)
    else $error("ambient divide pending for more than one cycle");

  a_pend_in_mon: assert property (@(posedge clk) disable iff (!rst_n)
    amb_pend_r |-> (phase_r == olsd_pkg::PH_MON))
    else $error("ambient divide pending outside monitoring");

  a_start_opens_win: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && out_res_nxt.tx_valid && (out_res_nxt.tx_byte == olsd_pkg::BYTE_START))
    |=> (phase_r == olsd_pkg::PH_WIN) && (run_r == '0))
    else $error("start byte without window");

  a_tick_closes_win: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.op == olsd_pkg::OP_TICK) && (phase_r == olsd_pkg::PH_WIN))
    |=> (phase_r == olsd_pkg::PH_MON) && out_v_r && out_res_r.decision_valid)
    else $error("tick did not close window");

endmodule

`default_nettype wire

// ----- hw/rtl/optical_link_start_detector.sv -----
// channel  direction  handshake            payload
// in_      slave      in_tvalid/in_tready   tdata: nine samples, tuser: operation
// out_     master     out_tvalid/out_tready tdata: one result per transaction
// cfg_     write      cfg_we                cfg_addr 0 margin, 1 run_length
//
// one transaction per cycle while the back end runs; result via sum stage, queue, output register
// after the last calibration sweep the back end pauses for the ambient divide
// synchronous active-low reset; margin 3, run_length 200, phase calibrating
// a four-entry queue between front and back; in_tready drops when it and the sum stage are full
// out_tready low with a result held keeps the output register and stops the back end
`default_nettype none

module optical_link_start_detector #(
  parameter int CHANNELS    = olsd_pkg::CHANNELS_DEF,
  parameter int CAL_SWEEPS  = olsd_pkg::CAL_SWEEPS_DEF,
  parameter int SAMPLE_BITS = olsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // sample_0 .. sample_8, 10 bits each, zero padded
  input  wire logic [olsd_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation
  input  wire logic [olsd_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // detect, tx_valid, tx_byte, decision_valid, locked, phase, zero padded
  output logic [olsd_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [olsd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [olsd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic              push_valid;
  logic              push_full;
  olsd_pkg::item_t   push_item;
  logic              q_valid;
  logic              q_pop;
  olsd_pkg::item_t   q_item;
  olsd_pkg::result_t res;

  olsd_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_op      (in_tuser[olsd_pkg::OP_W-1:0]),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_item  (push_item)
  );

  olsd_queue #(
    .DEPTH (olsd_pkg::Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_item  (push_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  olsd_back #(
    .CAL_SWEEPS (CAL_SWEEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.phase, res.locked, res.decision_valid,
                      res.tx_byte, res.tx_valid, res.detect};

endmodule

`default_nettype wire

// ----- sim/olsd_checker.sv -----
`timescale 1ns / 1ps

module olsd_checker
  import olsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    n_checked,
  output int                    n_starts,
  output int                    n_locked,
  output int                    n_lost
);

  // detect sits in bit 0
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               locked;
    logic               decision_valid;
    logic [TX_W-1:0]    tx_byte;
    logic               tx_valid;
    logic               detect;
  } outcome_t;

  localparam int OUTCOME_W = $bits(outcome_t);

  logic [MARGIN_W-1:0]  margin_r;
  logic [RUNLEN_W-1:0]  run_limit;
  logic [PHASE_W-1:0]   ph;
  logic [SAMPLE_W-1:0]  ambient;
  logic [RUN_W-1:0]     run_cnt;
  logic [6:0]           cal_idx;
  logic [16:0]          cal_acc;
  logic [WIN_CNT_W-1:0] ones_cnt;
  logic [WIN_CNT_W-1:0] zeros_cnt;
  logic                 lock;

  outcome_t outcome_q[$];

  function automatic outcome_t step_detector(input logic [OP_W-1:0] op,
                                             input logic [IN_DATA_W-1:0] smp);
    outcome_t r;
    int acc;
    logic [SAMPLE_W-1:0] avg;
    logic hit;
    r = '0;
    acc = 0;
    for (int c = 0; c < SAMPLE_FIELDS; c++) begin
      acc += smp[c*SAMPLE_W +: SAMPLE_W];
    end
    avg = SAMPLE_W'(acc / CHANNELS_DEF);
    // threshold may go negative, then nothing is seen
    hit = int'(avg) < int'(ambient) - int'(margin_r);
    case (op)
      OP_RECAL: begin
        ph = PH_CAL;
        cal_idx = '0;
        cal_acc = '0;
        run_cnt = '0;
        ones_cnt = '0;
        zeros_cnt = '0;
        lock = 1'b0;
      end
      OP_SWEEP: begin
        if (ph == PH_CAL) begin
          cal_acc = cal_acc + avg;
          cal_idx = cal_idx + 7'd1;
          if (cal_idx >= CAL_SWEEPS_DEF) begin
            ambient = SAMPLE_W'(cal_acc / CAL_SWEEPS_DEF);
            cal_idx = '0;
            cal_acc = '0;
            run_cnt = '0;
            ph = PH_MON;
          end
        end else if (ph == PH_MON) begin
          r.detect = hit;
          if (hit) begin
            if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
          end else begin
            run_cnt = '0;
          end
          if (run_cnt > run_limit) begin
            r.tx_valid = 1'b1;
            r.tx_byte = BYTE_START;
            ones_cnt = '0;
            zeros_cnt = '0;
            run_cnt = '0;
            ph = PH_WIN;
          end
        end else begin
          r.detect = hit;
          if (hit) begin
            if (ones_cnt != '1) ones_cnt = ones_cnt + 1'b1;
          end else begin
            if (zeros_cnt != '1) zeros_cnt = zeros_cnt + 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (ph == PH_WIN) begin
          r.decision_valid = 1'b1;
          lock = ones_cnt >= zeros_cnt;
          if (!lock) begin
            r.tx_valid = 1'b1;
            r.tx_byte = BYTE_LOST;
          end
          run_cnt = '0;
          ph = PH_MON;
        end
      end
      default: begin
      end
    endcase
    r.locked = lock;
    r.phase = ph;
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      margin_r = MARGIN_RST;
      run_limit = RUNLEN_RST;
      ph = PH_CAL;
      ambient = '0;
      run_cnt = '0;
      cal_idx = '0;
      cal_acc = '0;
      ones_cnt = '0;
      zeros_cnt = '0;
      lock = 1'b0;
      outcome_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = outcome_t'(out_tdata[OUTCOME_W-1:0]);
        if (outcome_q.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          cmp_field("detect", want.detect, got.detect);
          cmp_field("tx_valid", want.tx_valid, got.tx_valid);
          cmp_field("tx_byte", want.tx_byte, got.tx_byte);
          cmp_field("decision_valid", want.decision_valid, got.decision_valid);
          cmp_field("locked", want.locked, got.locked);
          cmp_field("phase", want.phase, got.phase);
        end
      end
      if (in_tvalid && in_tready) begin
        want = step_detector(in_tuser, in_tdata);
        if (want.tx_valid && want.tx_byte == BYTE_START) n_starts++;
        if (want.decision_valid && want.locked) n_locked++;
        if (want.decision_valid && !want.locked) n_lost++;
        outcome_q.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_MARGIN:     margin_r = cfg_wdata[MARGIN_W-1:0];
          REG_RUN_LENGTH: run_limit = cfg_wdata[RUNLEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
    pending = outcome_q.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import olsd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // sample_0 .. sample_8, 10 bits each, zero padded
  logic [IN_USER_W-1:0]  in_tuser;   // operation
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // detect, tx_valid, tx_byte, decision_valid, locked, phase
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int n_checked;
  int n_starts;
  int n_locked;
  int n_lost;

  int items_sent;
  int cfg_writes;
  int burst_left;
  bit steady;
  int cur_margin;
  int cur_run;
  int cal_level;
  int cal_spread;
  int idle_cycles;

  optical_link_start_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  olsd_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_starts   (n_starts),
    .n_locked   (n_locked),
    .n_lost     (n_lost)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: segments of always ready, mostly ready, mostly stalled, long stall
  initial begin
    int mode;
    int len;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(16, 64);
      for (int j = 0; j < len; j++) begin
        @(negedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (j >= 12);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] sweep_word(input int level, input int spread);
    logic [IN_DATA_W-1:0] w;
    int v;
    w = '0;
    for (int c = 0; c < SAMPLE_FIELDS; c++) begin
      v = level + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      w[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(v);
    end
    return w;
  endfunction

  function automatic logic [IN_DATA_W-1:0] noise_word();
    logic [IN_DATA_W-1:0] w;
    w = '0;
    for (int c = 0; c < SAMPLE_FIELDS; c++) begin
      w[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 1023));
    end
    return w;
  endfunction

  task automatic put(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 12);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (addr == REG_MARGIN) cur_margin = value;
    else cur_run = value;
  endtask

  task automatic dark();
    int level;
    level = cal_level - cal_spread - cur_margin - 4 - $urandom_range(0, 20);
    if (level < 0) level = 0;
    put(OP_SWEEP, sweep_word(level, 2));
  endtask

  task automatic light();
    int level;
    level = cal_level + cal_spread + $urandom_range(0, 20);
    if (level > 1023) level = 1023;
    put(OP_SWEEP, sweep_word(level, 0));
  endtask

  task automatic calibrate(input int level, input int spread);
    cal_level = level;
    cal_spread = spread;
    put(OP_RECAL, noise_word());
    repeat (CAL_SWEEPS_DEF) put(OP_SWEEP, sweep_word(level, spread));
  endtask

  task automatic traffic(input int n_items);
    int target;
    int k;
    int n;
    int bias;
    target = items_sent + n_items;
    while (items_sent < target) begin
      k = $urandom_range(0, 99);
      if (k < 55 && cur_run <= 60) begin
        repeat (cur_run + 1) dark();
        n = $urandom_range(0, 16);
        bias = $urandom_range(0, 100);
        repeat (n) begin
          if ($urandom_range(0, 99) < 4) put(OP_SPARE, noise_word());
          else if ($urandom_range(0, 99) < bias) dark();
          else light();
        end
        if ($urandom_range(0, 19) == 0) calibrate(cal_level, cal_spread);
        else put(OP_TICK, noise_word());
      end else if (k < 72) begin
        n = $urandom_range(0, (cur_run > 60) ? 60 : cur_run);
        repeat (n) dark();
        light();
      end else if (k < 82) begin
        repeat ($urandom_range(1, 6)) light();
      end else if (k < 88) begin
        put(OP_TICK, noise_word());
      end else if (k < 94) begin
        put(OP_SPARE, noise_word());
      end else begin
        put(OP_SWEEP, noise_word());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_SWEEP;
    cfg_we = 1'b0;
    cfg_addr = REG_MARGIN;
    cfg_wdata = '0;
    idle_cycles = 0;
    items_sent = 0;
    cfg_writes = 0;
    burst_left = 0;
    steady = 1'b0;
    cur_margin = MARGIN_RST;
    cur_run = RUNLEN_RST;
    cal_level = 0;
    cal_spread = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes and ignored items while calibrating
    put(OP_SWEEP, '0);
    put(OP_SWEEP, {6'd0, {9{10'h3FF}}});
    put(OP_SPARE, {6'd0, {9{10'h3FF}}});
    put(OP_TICK, {6'd0, {9{10'h3FF}}});
    put(OP_SPARE, '0);
    put(OP_SWEEP, {6'd0, {9{10'h2AA}}});
    put(OP_SWEEP, {6'd0, {9{10'h155}}});
    put(OP_TICK, '0);

    // reset settings: long run before a start
    calibrate(600, 20);
    put(OP_TICK, noise_word());
    put(OP_SPARE, noise_word());
    repeat (cur_run + 1) dark();
    repeat (5) dark();
    light();
    put(OP_TICK, noise_word());

    // zero margin: exact threshold, empty and tied windows, recal inside a window
    write_reg(REG_MARGIN, 0);
    write_reg(REG_RUN_LENGTH, 1);
    calibrate(512, 0);
    put(OP_SWEEP, {6'd0, {9{10'd512}}});
    put(OP_SWEEP, {6'd0, 10'd511, {8{10'd512}}});
    put(OP_SWEEP, {6'd0, 10'd511, {8{10'd512}}});
    put(OP_TICK, noise_word());
    repeat (2) dark();
    dark();
    light();
    put(OP_TICK, noise_word());
    repeat (2) dark();
    repeat (3) dark();
    calibrate(512, 0);
    traffic(120);

    // margin above ambient: threshold negative
    write_reg(REG_MARGIN, 1023);
    write_reg(REG_RUN_LENGTH, 5);
    calibrate(300, 10);
    traffic(40);

    write_reg(REG_MARGIN, 10);
    write_reg(REG_RUN_LENGTH, 40);
    calibrate(1000, 5);
    repeat (cur_run + 1) dark();
    repeat (6) light();
    put(OP_TICK, noise_word());
    traffic(40);

    // run counter pinned at its top, then a start right after lowering the limit
    write_reg(REG_MARGIN, 1);
    write_reg(REG_RUN_LENGTH, 255);
    steady = 1'b1;
    calibrate(900, 3);
    repeat (262) dark();
    write_reg(REG_RUN_LENGTH, 254);
    dark();
    repeat (4) dark();
    put(OP_TICK, noise_word());
    steady = 1'b0;

    write_reg(REG_MARGIN, 10);
    write_reg(REG_RUN_LENGTH, 3);
    calibrate(5, 5);
    traffic(40);

    repeat (3) begin
      write_reg(REG_MARGIN, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120));
      write_reg(REG_RUN_LENGTH, $urandom_range(1, 24));
      calibrate($urandom_range(40, 1000), $urandom_range(0, 30));
      traffic(20);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("%0d input transactions over %0d register writes, %0d results checked",
             items_sent, cfg_writes, n_checked);
    $display("%0d start windows opened, %0d closed locked, %0d closed with lock lost",
             n_starts, n_locked, n_lost);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/olsd_pkg.sv
hw/rtl/olsd_front.sv
hw/rtl/olsd_queue.sv
hw/rtl/olsd_back.sv
hw/rtl/optical_link_start_detector.sv
sim/olsd_checker.sv
sim/tb.sv
